FILE: hw/rtl/kmeans_l1_clustering_defines.svh
// assertion macros shared by the kmeans l1 clustering rtl
// no dependencies; included by files that carry concurrent checks
`ifndef KMEANS_L1_CLUSTERING_DEFINES_SVH
`define KMEANS_L1_CLUSTERING_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KML1_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KML1_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/kml1_pkg.sv
// shared constants, codes and controller/datapath interface types
// no dependencies; imported by every kmeans l1 clustering module
package kml1_pkg;

    // fixed field widths of the command and config ports
    localparam int ACT_W      = 3;
    localparam int PIDX_W     = 10;
    localparam int CIDX_W     = 3;
    localparam int FIDX_W     = 2;
    localparam int RC_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NK_W       = 4;
    localparam int IT_W       = 8;
    localparam int NP_W       = 11;
    localparam int ND_W       = 3;

    // actions
    localparam logic [ACT_W-1:0] ACT_LOAD_PT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_CT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RUN     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_LBL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RD_CT   = 3'd4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 2'd3;

    // config reset values
    localparam logic [NK_W-1:0] RST_NUM_CLUSTERS = 4'd2;
    localparam logic [IT_W-1:0] RST_ITERATIONS   = 8'd1;
    localparam logic [NP_W-1:0] RST_NUM_POINTS   = 11'd1024;
    localparam logic [ND_W-1:0] RST_NUM_DIMS     = 3'd4;

    // result kinds
    localparam logic [1:0] RES_OTHER = 2'd0;
    localparam logic [1:0] RES_LABEL = 2'd1;
    localparam logic [1:0] RES_CENT  = 2'd2;

    typedef struct packed {
        logic       pt_we;
        logic       pt_rd;
        logic       pf_cap;
        logic       ct_we;
        logic       ct_src_div;
        logic       ct_rd;
        logic       d_issue;
        logic       d_first;
        logic       d_last;
        logic       lbl_we;
        logic       lbl_clr;
        logic       lbl_rd;
        logic       pass_clr;
        logic       label_step;
        logic       upd_sel;
        logic       div_start;
        logic       res_load;
        logic [1:0] res_kind;
        logic       res_st;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_nz;
        logic div_done;
    } t_dp_stat;

endpackage

FILE: hw/rtl/kml1_div.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle
// uses kml1_pkg; instantiated by kml1_dp
module kml1_div #(
    parameter int SUM_W = 26,
    parameter int CNT_W = 11,
    parameter int Q_W   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic        [CNT_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [Q_W-1:0]   o_quot
);
    import kml1_pkg::*;

    localparam int CT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic [CT_W-1:0]  r_cnt;
    logic [CNT_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic             r_neg;
    logic [CNT_W-1:0] r_dvs;
    logic [CNT_W:0]   rem_sh;
    logic             fits;
    logic [SUM_W-1:0] q_signed;

    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign fits     = (rem_sh >= {1'b0, r_dvs});
    assign o_done   = r_busy && (r_cnt == '0);
    assign q_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quot   = q_signed[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CT_W'(SUM_W);
            r_rem <= '0;
            r_neg <= i_dividend[SUM_W-1];
            r_dvs <= i_divisor;
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
        end else if (r_busy && (r_cnt != '0)) begin
            r_cnt <= r_cnt - CT_W'(1);
            if (fits) begin
                r_rem <= CNT_W'(rem_sh - {1'b0, r_dvs});
                r_quo <= {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: hw/rtl/kml1_dp.sv
// datapath: point, centroid and label memories, distance pipeline,
// per-cluster sums and counts, result registers; uses kml1_pkg and kml1_div
module kml1_dp #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIMS     = 4,
    parameter int MAX_CLUSTERS = 8,
    parameter int FEATURE_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  kml1_pkg::t_dp_cmd                            i_cmd,
    output kml1_pkg::t_dp_stat                           o_stat,
    input  logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]       i_pt_addr,
    input  logic [$clog2(MAX_CLUSTERS*MAX_DIMS)-1:0]     i_ct_addr,
    input  logic [$clog2(MAX_POINTS)-1:0]                i_lbl_waddr,
    input  logic [$clog2(MAX_POINTS)-1:0]                i_lbl_raddr,
    input  logic [$clog2(MAX_CLUSTERS)-1:0]              i_j,
    input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] i_k,
    input  logic signed [FEATURE_BITS-1:0]               i_value,
    output logic                                         o_done,
    output logic signed [FEATURE_BITS-1:0]               o_read_value,
    output logic [kml1_pkg::RC_W-1:0]                    o_read_cluster,
    output logic                                         o_status
);
    import kml1_pkg::*;

    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int DI_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SUM_W  = FEATURE_BITS + $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = FEATURE_BITS + 1 + $clog2(MAX_DIMS);

    // memories
    logic signed [FEATURE_BITS-1:0] m_pt  [MAX_POINTS*MAX_DIMS];
    logic signed [FEATURE_BITS-1:0] m_ct  [MAX_CLUSTERS*MAX_DIMS];
    logic        [CL_W-1:0]         m_lbl [MAX_POINTS];
    logic signed [FEATURE_BITS-1:0] r_pt_q;
    logic signed [FEATURE_BITS-1:0] r_ct_q;
    logic        [CL_W-1:0]         r_lbl_q;

    // point feature buffer
    logic signed [FEATURE_BITS-1:0] r_pf [MAX_DIMS];
    logic                           r_cap1;
    logic [DI_W-1:0]                r_capk;

    // distance pipeline
    logic                    r_v1, r_f1, r_l1, r_v2, r_f2, r_l2, r_l3;
    logic [DI_W-1:0]         r_k1;
    logic [CL_W-1:0]         r_j1, r_j2, r_j3, r_bestj;
    logic [FEATURE_BITS:0]   r_ad;
    logic [DIST_W-1:0]       r_acc, r_best;
    logic signed [FEATURE_BITS:0] diff;

    // accumulation
    logic signed [SUM_W-1:0] r_sum [MAX_CLUSTERS][MAX_DIMS];
    logic [CNT_W-1:0]        r_cnt [MAX_CLUSTERS];
    logic [CL_W-1:0]         sel_j;

    // divider
    logic                           div_done;
    logic signed [FEATURE_BITS-1:0] div_q;

    // result
    logic       r_res_v;
    logic [1:0] r_res_kind;
    logic       r_res_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_we) begin
            m_pt[i_pt_addr] <= i_value;
        end
        if (i_cmd.pt_rd) begin
            r_pt_q <= m_pt[i_pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ct_we) begin
            m_ct[i_ct_addr] <= i_cmd.ct_src_div ? div_q : i_value;
        end
        if (i_cmd.ct_rd) begin
            r_ct_q <= m_ct[i_ct_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lbl_we) begin
            m_lbl[i_lbl_waddr] <= i_cmd.lbl_clr ? '0 : r_bestj;
        end
        if (i_cmd.lbl_rd) begin
            r_lbl_q <= m_lbl[i_lbl_raddr];
        end
    end

    // feature buffer fill, in the cycle after the point read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap1 <= 1'b0;
        end else begin
            r_cap1 <= i_cmd.pf_cap;
        end
        r_capk <= i_k;
        if (r_cap1) begin
            r_pf[r_capk] <= r_pt_q;
        end
    end

    assign diff = (FEATURE_BITS+1)'(r_pf[r_k1]) - (FEATURE_BITS+1)'(r_ct_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_l3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.d_issue;
            r_v2 <= r_v1;
            r_l3 <= r_v2 && r_l2;
        end
        r_f1 <= i_cmd.d_first;
        r_l1 <= i_cmd.d_last;
        r_k1 <= i_k;
        r_j1 <= i_j;
        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_j2 <= r_j1;
        r_ad <= diff[FEATURE_BITS] ? (FEATURE_BITS+1)'(-diff) : (FEATURE_BITS+1)'(diff);
        r_j3 <= r_j2;
        if (r_v2) begin
            r_acc <= (r_f2 ? '0 : r_acc) + DIST_W'(r_ad);
        end
        // ties keep the lower cluster
        if (r_l3 && ((r_j3 == '0) || (r_acc < r_best))) begin
            r_best  <= r_acc;
            r_bestj <= r_j3;
        end
    end

    assign sel_j = i_cmd.upd_sel ? i_j : r_bestj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_clr) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
                r_cnt[c] <= '0;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    r_sum[c][d] <= '0;
                end
            end
        end else if (i_cmd.label_step) begin
            r_cnt[sel_j] <= r_cnt[sel_j] + CNT_W'(1);
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_sum[sel_j][d] <= r_sum[sel_j][d] + SUM_W'(r_pf[d]);
            end
        end
    end

    assign o_stat.cnt_nz   = (r_cnt[sel_j] != '0);
    assign o_stat.div_done = div_done;

    kml1_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W),
        .Q_W   (FEATURE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum[sel_j][i_k]),
        .i_divisor  (r_cnt[sel_j]),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= i_cmd.res_load;
        end
        if (i_cmd.res_load) begin
            r_res_kind <= i_cmd.res_kind;
            r_res_st   <= i_cmd.res_st;
        end
    end

    assign o_done         = r_res_v;
    assign o_status       = r_res_st;
    assign o_read_value   = (r_res_kind == RES_CENT && !r_res_st) ? r_ct_q : '0;
    assign o_read_cluster = (r_res_kind == RES_LABEL && !r_res_st) ? RC_W'(r_lbl_q) : '0;

endmodule

FILE: hw/rtl/kml1_ctrl.sv
// controller: config registers, command decode and the run sequencer
// uses kml1_pkg and the assertion macros header; drives kml1_dp
`include "kmeans_l1_clustering_defines.svh"
module kml1_ctrl #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIMS     = 4,
    parameter int MAX_CLUSTERS = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         start,
    output logic                                         busy,
    input  logic [kml1_pkg::ACT_W-1:0]                   i_action,
    input  logic [kml1_pkg::PIDX_W-1:0]                  i_point_index,
    input  logic [kml1_pkg::CIDX_W-1:0]                  i_cluster_index,
    input  logic [kml1_pkg::FIDX_W-1:0]                  i_feature_index,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [kml1_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [kml1_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    output kml1_pkg::t_dp_cmd                            o_cmd,
    input  kml1_pkg::t_dp_stat                           i_stat,
    output logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]       o_pt_addr,
    output logic [$clog2(MAX_CLUSTERS*MAX_DIMS)-1:0]     o_ct_addr,
    output logic [$clog2(MAX_POINTS)-1:0]                o_lbl_waddr,
    output logic [$clog2(MAX_POINTS)-1:0]                o_lbl_raddr,
    output logic [$clog2(MAX_CLUSTERS)-1:0]              o_j,
    output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] o_k
);
    import kml1_pkg::*;

    localparam int PI_W  = $clog2(MAX_POINTS);
    localparam int CL_W  = $clog2(MAX_CLUSTERS);
    localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PA_W  = $clog2(MAX_POINTS*MAX_DIMS);
    localparam int CA_W  = $clog2(MAX_CLUSTERS*MAX_DIMS);
    localparam int NPE_W = $clog2(MAX_POINTS + 1);
    localparam int NKE_W = $clog2(MAX_CLUSTERS + 1);
    localparam int NDE_W = $clog2(MAX_DIMS + 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LDP   = 4'd2;
    localparam logic [3:0] S_DIST  = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_LABEL = 4'd5;
    localparam logic [3:0] S_UJ    = 4'd6;
    localparam logic [3:0] S_UK    = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;

    // drain step after which the best cluster holds the last distance result
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [NK_W-1:0] r_nk_cfg;
    logic [IT_W-1:0] r_iter;
    logic [NP_W-1:0] r_np_cfg;
    logic [ND_W-1:0] r_nd_cfg;

    logic [3:0]      r_state, n_state;
    logic [PI_W-1:0] r_i, n_i;
    logic [CL_W-1:0] r_j, n_j;
    logic [DI_W-1:0] r_k, n_k;
    logic [IT_W-1:0] r_pass, n_pass;
    logic [1:0]      r_dr, n_dr;

    logic [NPE_W-1:0] np_e;
    logic [NKE_W-1:0] nk_e;
    logic [NDE_W-1:0] nd_e;
    logic pi_ok, ci_ok, fi_ok, i_last, j_last, k_last, clr_last;
    t_dp_cmd cmd;

    // effective sizes, saturated to one and the maximum
    always_comb begin
        if (r_np_cfg == '0) begin
            np_e = NPE_W'(1);
        end else if (32'(r_np_cfg) > 32'(MAX_POINTS)) begin
            np_e = NPE_W'(MAX_POINTS);
        end else begin
            np_e = NPE_W'(r_np_cfg);
        end
        if (r_nk_cfg == '0) begin
            nk_e = NKE_W'(1);
        end else if (32'(r_nk_cfg) > 32'(MAX_CLUSTERS)) begin
            nk_e = NKE_W'(MAX_CLUSTERS);
        end else begin
            nk_e = NKE_W'(r_nk_cfg);
        end
        if (r_nd_cfg == '0) begin
            nd_e = NDE_W'(1);
        end else if (32'(r_nd_cfg) > 32'(MAX_DIMS)) begin
            nd_e = NDE_W'(MAX_DIMS);
        end else begin
            nd_e = NDE_W'(r_nd_cfg);
        end
    end

    assign pi_ok    = 32'(i_point_index) < 32'(np_e);
    assign ci_ok    = 32'(i_cluster_index) < 32'(nk_e);
    assign fi_ok    = 32'(i_feature_index) < 32'(nd_e);
    assign i_last   = (32'(r_i) + 32'd1) == 32'(np_e);
    assign j_last   = (32'(r_j) + 32'd1) == 32'(nk_e);
    assign k_last   = (32'(r_k) + 32'd1) == 32'(nd_e);
    assign clr_last = (32'(r_i) + 32'd1) == 32'(MAX_POINTS);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_pass  = r_pass;
        n_dr    = r_dr;
        cmd     = '0;
        case (r_state)
            S_CLR: begin
                cmd.lbl_we  = 1'b1;
                cmd.lbl_clr = 1'b1;
                if (clr_last) begin
                    n_state = S_IDLE;
                    n_i     = '0;
                end else begin
                    n_i = r_i + PI_W'(1);
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.res_kind = RES_OTHER;
                    case (i_action)
                        ACT_LOAD_PT: begin
                            cmd.pt_we    = pi_ok && fi_ok;
                            cmd.res_load = 1'b1;
                            cmd.res_st   = !(pi_ok && fi_ok);
                        end
                        ACT_LOAD_CT: begin
                            cmd.ct_we    = ci_ok && fi_ok;
                            cmd.res_load = 1'b1;
                            cmd.res_st   = !(ci_ok && fi_ok);
                        end
                        ACT_RUN: begin
                            cmd.pass_clr = 1'b1;
                            n_pass  = '0;
                            n_i     = '0;
                            n_k     = '0;
                            n_state = S_LDP;
                        end
                        ACT_RD_LBL: begin
                            cmd.lbl_rd   = pi_ok;
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_LABEL;
                            cmd.res_st   = !pi_ok;
                        end
                        ACT_RD_CT: begin
                            cmd.ct_rd    = ci_ok && fi_ok;
                            cmd.res_load = 1'b1;
                            cmd.res_kind = RES_CENT;
                            cmd.res_st   = !(ci_ok && fi_ok);
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                            cmd.res_st   = 1'b1;
                        end
                    endcase
                end
            end
            S_LDP: begin
                cmd.pt_rd  = 1'b1;
                cmd.pf_cap = 1'b1;
                if (k_last) begin
                    n_k     = '0;
                    n_j     = '0;
                    n_state = S_DIST;
                end else begin
                    n_k = r_k + DI_W'(1);
                end
            end
            S_DIST: begin
                cmd.ct_rd   = 1'b1;
                cmd.d_issue = 1'b1;
                cmd.d_first = (r_k == '0);
                cmd.d_last  = k_last;
                if (k_last) begin
                    n_k = '0;
                    if (j_last) begin
                        n_dr    = '0;
                        n_state = S_DRAIN;
                    end else begin
                        n_j = r_j + CL_W'(1);
                    end
                end else begin
                    n_k = r_k + DI_W'(1);
                end
            end
            S_DRAIN: begin
                if (r_dr == DRAIN_LAST) begin
                    n_state = S_LABEL;
                end else begin
                    n_dr = r_dr + 2'd1;
                end
            end
            S_LABEL: begin
                cmd.lbl_we     = 1'b1;
                cmd.label_step = 1'b1;
                n_k = '0;
                if (i_last) begin
                    n_j     = '0;
                    n_state = S_UJ;
                end else begin
                    n_i     = r_i + PI_W'(1);
                    n_state = S_LDP;
                end
            end
            S_UJ: begin
                cmd.upd_sel = 1'b1;
                if (i_stat.cnt_nz) begin
                    n_k     = '0;
                    n_state = S_UK;
                end else if (j_last) begin
                    n_state = S_NEXT;
                end else begin
                    n_j = r_j + CL_W'(1);
                end
            end
            S_UK: begin
                cmd.upd_sel   = 1'b1;
                cmd.div_start = 1'b1;
                n_state       = S_DIVW;
            end
            S_DIVW: begin
                cmd.upd_sel = 1'b1;
                if (i_stat.div_done) begin
                    cmd.ct_we      = 1'b1;
                    cmd.ct_src_div = 1'b1;
                    if (!k_last) begin
                        n_k     = r_k + DI_W'(1);
                        n_state = S_UK;
                    end else if (j_last) begin
                        n_state = S_NEXT;
                    end else begin
                        n_j     = r_j + CL_W'(1);
                        n_state = S_UJ;
                    end
                end
            end
            S_NEXT: begin
                if (r_pass == r_iter) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_OTHER;
                    n_state      = S_IDLE;
                end else begin
                    cmd.pass_clr = 1'b1;
                    n_pass  = r_pass + IT_W'(1);
                    n_i     = '0;
                    n_k     = '0;
                    n_state = S_LDP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_pass  <= '0;
            r_dr    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_pass  <= n_pass;
            r_dr    <= n_dr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nk_cfg <= RST_NUM_CLUSTERS;
            r_iter   <= RST_ITERATIONS;
            r_np_cfg <= RST_NUM_POINTS;
            r_nd_cfg <= RST_NUM_DIMS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_CLUSTERS: r_nk_cfg <= i_cfg_data[NK_W-1:0];
                CFG_ITERATIONS:   r_iter   <= i_cfg_data[IT_W-1:0];
                CFG_NUM_POINTS:   r_np_cfg <= i_cfg_data[NP_W-1:0];
                CFG_NUM_DIMS:     r_nd_cfg <= i_cfg_data[ND_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_cmd       = cmd;
    assign o_lbl_waddr = r_i;
    assign o_lbl_raddr = PI_W'(i_point_index);
    assign o_j         = r_j;
    assign o_k         = r_k;
    assign o_pt_addr   = (r_state == S_IDLE)
        ? PA_W'(32'(i_point_index) * MAX_DIMS + 32'(i_feature_index))
        : PA_W'(32'(r_i) * MAX_DIMS + 32'(r_k));
    assign o_ct_addr   = (r_state == S_IDLE)
        ? CA_W'(32'(i_cluster_index) * MAX_DIMS + 32'(i_feature_index))
        : CA_W'(32'(r_j) * MAX_DIMS + 32'(r_k));

    `KML1_ASSERT_NXT(a_run_starts_pass, i_clk, i_rst_n, r_state == S_IDLE && start && i_action == ACT_RUN, r_state == S_LDP, "run accepted without entering the point load")
    `KML1_ASSERT_IMP(a_result_origin, i_clk, i_rst_n, cmd.res_load, r_state == S_IDLE || r_state == S_NEXT, "result issued mid-run")
    `KML1_ASSERT_IMP(a_div_nonempty, i_clk, i_rst_n, cmd.div_start, i_stat.cnt_nz, "division started for an empty cluster")

endmodule

FILE: hw/rtl/kmeans_l1_clustering.sv
// top level of the kmeans l1 clustering engine
// uses kml1_pkg; instantiates kml1_ctrl and kml1_dp
//
// Command-driven k-means engine with Manhattan distance. A command is taken
// on a clock edge with start high and busy low; every command produces one
// result, shown for a single cycle with o_done high, and the receiver cannot
// stall it. Point and centroid loads and label and centroid reads are done in
// the idle state and may issue back to back, with the result in the next cycle.
// A run holds busy high for iterations+1 passes; in each pass labeling is
// bound by the single centroid memory read port, and the centroid update of
// each non-empty cluster by the bit-serial divider over SUM_W bits, where SUM_W
// is FEATURE_BITS plus log2(MAX_POINTS). After reset all MAX_POINTS label
// entries are cleared with busy high; configuration writes are taken at any
// time but must only change while no command is in flight.
module kmeans_l1_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_DIMS     = 4,
    parameter int MAX_CLUSTERS = 8,
    parameter int FEATURE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command transaction
    input  logic                                 start,
    output logic                                 busy,
    input  logic [kml1_pkg::ACT_W-1:0]           i_action,
    input  logic [kml1_pkg::PIDX_W-1:0]          i_point_index,
    input  logic [kml1_pkg::CIDX_W-1:0]          i_cluster_index,
    input  logic [kml1_pkg::FIDX_W-1:0]          i_feature_index,
    input  logic signed [FEATURE_BITS-1:0]       i_value,
    // result transaction
    output logic                                 o_done,
    output logic signed [FEATURE_BITS-1:0]       o_read_value,
    output logic [kml1_pkg::RC_W-1:0]            o_read_cluster,
    output logic                                 o_status,
    // configuration write transaction
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kml1_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kml1_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import kml1_pkg::*;

    localparam int PI_W = $clog2(MAX_POINTS);
    localparam int CL_W = $clog2(MAX_CLUSTERS);
    localparam int DI_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int PA_W = $clog2(MAX_POINTS*MAX_DIMS);
    localparam int CA_W = $clog2(MAX_CLUSTERS*MAX_DIMS);

    t_dp_cmd         cmd;
    t_dp_stat        stat;
    logic [PA_W-1:0] pt_addr;
    logic [CA_W-1:0] ct_addr;
    logic [PI_W-1:0] lbl_waddr;
    logic [PI_W-1:0] lbl_raddr;
    logic [CL_W-1:0] sel_j;
    logic [DI_W-1:0] sel_k;

    // sequencer: decode, config registers, pass and index counters
    kml1_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_DIMS     (MAX_DIMS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_point_index   (i_point_index),
        .i_cluster_index (i_cluster_index),
        .i_feature_index (i_feature_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cmd           (cmd),
        .i_stat          (stat),
        .o_pt_addr       (pt_addr),
        .o_ct_addr       (ct_addr),
        .o_lbl_waddr     (lbl_waddr),
        .o_lbl_raddr     (lbl_raddr),
        .o_j             (sel_j),
        .o_k             (sel_k)
    );

    // memories, distance pipeline, sums, divider and result registers
    kml1_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_DIMS     (MAX_DIMS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_pt_addr      (pt_addr),
        .i_ct_addr      (ct_addr),
        .i_lbl_waddr    (lbl_waddr),
        .i_lbl_raddr    (lbl_raddr),
        .i_j            (sel_j),
        .i_k            (sel_k),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_read_value   (o_read_value),
        .o_read_cluster (o_read_cluster),
        .o_status       (o_status)
    );

endmodule
